// File: rtl/core/prte_pkg.sv
// Shared types, constants and coefficient tables of the pulse resistance
// temperature estimator. No dependencies.
`default_nettype none

package prte_pkg;

	// Field widths
	localparam int CUR_W   = 19;
	localparam int VOLT_W  = 16;
	localparam int TIME_W  = 32;
	localparam int TEMP_W  = 15;
	localparam int SOC_W   = 10;
	localparam int THR_W   = 18;
	localparam int SETTLE_W = 16;
	localparam int DI_W    = 20;
	localparam int DV_W    = 17;
	localparam int ADI_W   = 20;
	localparam int ADV_W   = 16;

	// Configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 18;
	localparam logic [CFG_IDX_W-1:0] CFG_SOC    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_THR    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SETTLE = 2'd2;
	localparam logic [SOC_W-1:0]    SOC_RESET    = 10'd500;
	localparam logic [THR_W-1:0]    THR_RESET    = 18'd10000;
	localparam logic [SETTLE_W-1:0] SETTLE_RESET = 16'd150;

	// Job queue between front and back
	localparam int QDEPTH = 4;

	// Table row = soc / 100 via reciprocal 41 / 4096, exact over 0..1023
	localparam int ROW_W = 4;
	localparam logic [ROW_W-1:0] ROW_MAX = 4'd10;
	localparam logic [5:0] SOC_RECIP = 6'd41;
	localparam int SOC_PROD_W = 16;

	// Resistance window multipliers (5 and 100 milliohm)
	localparam logic [23:0] RWIN_LO_MUL = 24'd200;
	localparam logic [19:0] RWIN_HI_MUL = 20'd10;

	// Coefficient widths
	localparam int R0_W = 38;
	localparam int R1_W = 36;
	localparam int EA_W = 19;

	// Numerator accumulation, pico-ohm scale
	localparam int ACC_W = 64;
	localparam logic [ACC_W-1:0] PICO_PER_OHM = 64'd1000000000000;
	localparam int NUM_STEPS = ADI_W;

	// Logarithm unit
	localparam int LOG_IN_W = 64;
	localparam int LOG_FRAC = 24;
	localparam int LOG_W    = 30;
	localparam int LOG_K_W  = LOG_W - LOG_FRAC;
	localparam int MANT_W   = 31;

	// Divider and temperature scaling
	localparam int D_W    = 32;
	localparam int DEN_W  = 31;
	localparam int REM_W  = DEN_W + 1;
	localparam int DIV_W  = 45;
	localparam int CNT_W  = 6;
	localparam int SCALE_W = 25;
	localparam logic [SCALE_W-1:0] TEMP_SCALE =
		SCALE_W'((64'd1 << 24) * 64'd1000000000 / 64'd597308025);
	localparam logic [15:0] KELVIN_CENTI = 16'd27315;
	localparam logic [DIV_W-1:0] TCK_MIN = 45'd25315;
	localparam logic [DIV_W-1:0] TCK_MAX = 45'd37315;
	localparam logic [TEMP_W-1:0] TEMP_BIAS  = 15'd2000;
	localparam logic [TEMP_W-1:0] TEMP_RESET = 15'd2500;

	// One classified sample handed from front to back
	typedef struct packed {
		logic                   est;
		logic                   pending;
		logic signed [DI_W-1:0] di;
		logic signed [DV_W-1:0] dv;
	} job_t;

	// Arrhenius offset r0 in pico-ohm
	function automatic logic signed [R0_W-1:0] r0_of(input logic [ROW_W-1:0] row);
		unique case (row) inside
			4'd0, 4'd1: r0_of = -38'sd81636000000;
			4'd2:       r0_of = 38'sd5101000000;
			4'd3:       r0_of = 38'sd9964000000;
			4'd4:       r0_of = 38'sd9108000000;
			4'd5:       r0_of = 38'sd4168000000;
			4'd6:       r0_of = 38'sd1307000000;
			4'd7:       r0_of = 38'sd4737000000;
			4'd8:       r0_of = 38'sd10057000000;
			default:    r0_of = 38'sd6521000000;
		endcase
	endfunction

	// Arrhenius scale r1 in pico-ohm
	function automatic logic [R1_W-1:0] r1_of(input logic [ROW_W-1:0] row);
		unique case (row) inside
			4'd0, 4'd1: r1_of = 36'd34802540000;
			4'd2:       r1_of = 36'd3867334;
			4'd3:       r1_of = 36'd17609;
			4'd4:       r1_of = 36'd97125;
			4'd5:       r1_of = 36'd5307442;
			4'd6:       r1_of = 36'd20457790;
			4'd7:       r1_of = 36'd1997041;
			4'd8:       r1_of = 36'd12824;
			default:    r1_of = 36'd430475;
		endcase
	endfunction

	// Activation energy in micro-eV
	function automatic logic [EA_W-1:0] ea_of(input logic [ROW_W-1:0] row);
		unique case (row) inside
			4'd0, 4'd1: ea_of = 19'd27305;
			4'd2:       ea_of = 19'd206345;
			4'd3:       ea_of = 19'd329481;
			4'd4:       ea_of = 19'd290453;
			4'd5:       ea_of = 19'd200746;
			4'd6:       ea_of = 19'd171306;
			4'd7:       ea_of = 19'd224720;
			4'd8:       ea_of = 19'd342309;
			default:    ea_of = 19'd262706;
		endcase
	endfunction

endpackage

`default_nettype wire

// File: rtl/core/prte_front.sv
// Front end: accepts samples, tracks anchors and pulse timing, and
// classifies each sample into a job. Depends on prte_pkg.
`default_nettype none

module prte_front (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic signed [prte_pkg::CUR_W-1:0]    current_ma,
	input  logic [prte_pkg::VOLT_W-1:0]          voltage_mv,
	input  logic [prte_pkg::TIME_W-1:0]          time_ms,
	input  logic [prte_pkg::THR_W-1:0]           thr,
	input  logic [prte_pkg::SETTLE_W-1:0]        settle_ms,
	input  logic                                 q_full,
	output logic                                 q_push,
	output prte_pkg::job_t                       q_job
);
	import prte_pkg::*;

	logic                     pulse_active_q;
	logic [TIME_W-1:0]        pulse_start_q;
	logic signed [CUR_W-1:0]  anchor_cur_q;
	logic [VOLT_W-1:0]        anchor_volt_q;

	logic signed [DI_W-1:0]   diff;
	logic [DI_W-1:0]          mag;
	logic                     step;
	logic [TIME_W-1:0]        elapsed;
	logic                     settled;
	logic                     accept;

	// step and settle detection
	always_comb begin
		diff    = DI_W'(current_ma) - DI_W'(anchor_cur_q);
		mag     = diff[DI_W-1] ? -diff : diff;
		step    = mag > DI_W'(thr);
		elapsed = time_ms - pulse_start_q;
		settled = elapsed >= TIME_W'(settle_ms);
	end

	// job for the back end
	always_comb begin
		q_job.est     = pulse_active_q && settled;
		q_job.pending = pulse_active_q ? !settled : step;
		q_job.di      = diff;
		q_job.dv      = DV_W'({1'b0, voltage_mv}) - DV_W'({1'b0, anchor_volt_q});
	end

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;
	assign q_push   = accept;

	// pulse tracking state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pulse_active_q <= 1'b0;
			pulse_start_q  <= '0;
			anchor_cur_q   <= '0;
			anchor_volt_q  <= '0;
		end else if (accept) begin
			if (!pulse_active_q) begin
				if (step) begin
					pulse_active_q <= 1'b1;
					pulse_start_q  <= time_ms;
				end else begin
					anchor_cur_q  <= current_ma;
					anchor_volt_q <= voltage_mv;
				end
			end else if (settled) begin
				pulse_active_q <= 1'b0;
				anchor_cur_q   <= current_ma;
				anchor_volt_q  <= voltage_mv;
			end
		end
	end

endmodule

`default_nettype wire

// File: rtl/core/prte_fifo.sv
// Short job queue between front and back end.
// Depends on prte_pkg for job_t and the depth.
`default_nettype none

module prte_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  prte_pkg::job_t push_job,
	output logic           full,
	input  logic           pop,
	output prte_pkg::job_t head,
	output logic           empty
);
	import prte_pkg::*;

	localparam int PTR_W = $clog2(QDEPTH);
	localparam int CNT_QW = $clog2(QDEPTH + 1);

	job_t               mem_q [QDEPTH];
	logic [PTR_W-1:0]   wr_q;
	logic [PTR_W-1:0]   rd_q;
	logic [CNT_QW-1:0]  count_q;

	assign full  = count_q == CNT_QW'(QDEPTH);
	assign empty = count_q == '0;
	assign head  = mem_q[rd_q];

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_job;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !push) else $error("queue written while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		empty |-> !pop) else $error("queue read while empty");
	a_level: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_QW'(QDEPTH)) else $error("queue level out of range");

endmodule

`default_nettype wire

// File: rtl/core/prte_log2.sv
// Iterative base-2 logarithm in Q24: leading-one search, then one
// truncated squaring of the mantissa per cycle. Depends on prte_pkg.
`default_nettype none

module prte_log2 (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic [prte_pkg::LOG_IN_W-1:0]   n,
	output logic                            done,
	output logic [prte_pkg::LOG_W-1:0]      result
);
	import prte_pkg::*;

	localparam int SH_W  = $clog2(LOG_IN_W);
	localparam int BIT_W = $clog2(LOG_FRAC);

	typedef enum logic [2:0] {
		L_IDLE = 3'b001,
		L_NORM = 3'b010,
		L_SQ   = 3'b100
	} lstate_t;

	lstate_t               state_q;
	logic [LOG_IN_W-1:0]   x_q;
	logic [SH_W-1:0]       s_q;
	logic [MANT_W-1:0]     m_q;
	logic [BIT_W-1:0]      bit_q;
	logic [LOG_FRAC-1:0]   frac_q;
	logic                  done_q;
	logic [LOG_W-1:0]      res_q;

	logic [2*MANT_W-1:0]   sq;
	logic [MANT_W:0]       m2;
	logic [LOG_FRAC-1:0]   frac_n;
	logic [LOG_K_W-1:0]    k;

	// one squaring step
	always_comb begin
		sq     = (2*MANT_W)'(m_q) * (2*MANT_W)'(m_q);
		m2     = sq[2*MANT_W-1:MANT_W-1];
		frac_n = frac_q | (m2[MANT_W] ? (LOG_FRAC'(1) << bit_q) : '0);
		k      = LOG_K_W'(LOG_IN_W - 1) - LOG_K_W'(s_q);
	end

	assign done   = done_q;
	assign result = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= L_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				L_IDLE: begin
					if (start) begin
						state_q <= L_NORM;
					end
				end
				L_NORM: begin
					if (x_q[LOG_IN_W-1]) begin
						state_q <= L_SQ;
					end
				end
				L_SQ: begin
					if (bit_q == '0) begin
						state_q <= L_IDLE;
						done_q  <= 1'b1;
					end
				end
				default: state_q <= L_IDLE;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			L_IDLE: begin
				x_q    <= n;
				s_q    <= '0;
				frac_q <= '0;
			end
			L_NORM: begin
				// coarse shift by a byte, then bit by bit
				if (x_q[LOG_IN_W-1 -: 8] == '0) begin
					x_q <= x_q << 8;
					s_q <= s_q + SH_W'(8);
				end else if (!x_q[LOG_IN_W-1]) begin
					x_q <= x_q << 1;
					s_q <= s_q + 1'b1;
				end else begin
					m_q   <= x_q[LOG_IN_W-1 -: MANT_W];
					bit_q <= BIT_W'(LOG_FRAC - 1);
				end
			end
			L_SQ: begin
				m_q    <= m2[MANT_W] ? m2[MANT_W:1] : m2[MANT_W-1:0];
				frac_q <= frac_n;
				bit_q  <= bit_q - 1'b1;
				if (bit_q == '0) begin
					res_q <= {k, frac_n};
				end
			end
			default: ;
		endcase
	end

endmodule

`default_nettype wire

// File: rtl/core/prte_back.sv
// Back end: resistance check, logarithms, temperature division, moving
// average and the output register. Depends on prte_pkg and prte_log2.
`default_nettype none

module prte_back #(
	parameter int WINDOW = 8
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  q_empty,
	output logic                                  q_pop,
	input  prte_pkg::job_t                        q_job,
	input  logic [prte_pkg::SOC_W-1:0]            soc,
	input  logic [prte_pkg::THR_W-1:0]            thr,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic signed [prte_pkg::TEMP_W-1:0]    temp_centi_c,
	output logic                                  temp_valid,
	output logic                                  estimate_updated,
	output logic                                  pulse_pending
);
	import prte_pkg::*;

	localparam int WP_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
	localparam int FC_W  = $clog2(WINDOW + 1);
	localparam int SUM_W = TEMP_W + $clog2(WINDOW) + 1;

	typedef enum logic [13:0] {
		B_IDLE = 14'b00000000000001,
		B_CHK  = 14'b00000000000010,
		B_NUM  = 14'b00000000000100,
		B_LOGN = 14'b00000000001000,
		B_LOGA = 14'b00000000010000,
		B_LOGR = 14'b00000000100000,
		B_MULT = 14'b00000001000000,
		B_DSET = 14'b00000010000000,
		B_DIV  = 14'b00000100000000,
		B_TCHK = 14'b00001000000000,
		B_PUSH = 14'b00010000000000,
		B_SUM  = 14'b00100000000000,
		B_AVG  = 14'b01000000000000,
		B_OUT  = 14'b10000000000000
	} bstate_t;

	bstate_t                  state_q;
	job_t                     job_q;
	logic [ADI_W-1:0]         adi_q;
	logic [ADI_W-1:0]         mi_q;
	logic [ADV_W-1:0]         mv_q;
	logic signed [ACC_W-1:0]  acc_q;
	logic signed [ACC_W-1:0]  aterm_q;
	logic signed [ACC_W-1:0]  bterm_q;
	logic [CNT_W-1:0]         cnt_q;
	logic [LOG_W-1:0]         ln_q;
	logic [LOG_W-1:0]         la_q;
	logic [LOG_W-1:0]         lr_q;
	logic                     log_busy_q;
	logic [DEN_W-1:0]         d_q;
	logic [DIV_W-1:0]         prod_q;
	logic [DIV_W-1:0]         dnum_q;
	logic [DEN_W-1:0]         dden_q;
	logic [REM_W-1:0]         rem_q;
	logic                     avg_q;
	logic [TEMP_W-1:0]        t_q;
	logic signed [TEMP_W-1:0] hist_q [WINDOW];
	logic [WP_W-1:0]          wp_q;
	logic [FC_W-1:0]          fill_q;
	logic [FC_W-1:0]          idx_q;
	logic signed [SUM_W-1:0]  sum_q;
	logic [TEMP_W-1:0]        est_q;
	logic                     est_valid_q;
	logic                     upd_q;
	logic                     out_valid_q;
	logic [TEMP_W-1:0]        out_temp_q;
	logic                     out_tv_q;
	logic                     out_upd_q;
	logic                     out_pend_q;

	logic [SOC_PROD_W-1:0]    soc_x;
	logic [ROW_W-1:0]         row_raw;
	logic [ROW_W-1:0]         row;
	logic [ADI_W-1:0]         adi;
	logic [DV_W-1:0]          adv_full;
	logic [ADV_W-1:0]         adv;
	logic                     chk_pass;
	logic                     log_state;
	logic                     log_start;
	logic                     log_done;
	logic [LOG_W-1:0]         log_res;
	logic [LOG_IN_W-1:0]      log_in;
	logic signed [D_W-1:0]    d;
	logic [REM_W-1:0]         rem_sh;
	logic                     ge;
	logic signed [31:0]       biased;
	logic                     out_free;

	// table row from state of charge
	always_comb begin
		soc_x   = SOC_PROD_W'(soc) * SOC_PROD_W'(SOC_RECIP);
		row_raw = soc_x[SOC_PROD_W-1 -: ROW_W];
		row     = (row_raw > ROW_MAX) ? ROW_MAX : row_raw;
	end

	// step recheck and resistance window
	always_comb begin
		adi      = job_q.di[DI_W-1] ? -job_q.di : job_q.di;
		adv_full = job_q.dv[DV_W-1] ? -job_q.dv : job_q.dv;
		adv      = adv_full[ADV_W-1:0];
		chk_pass = ({adi, 1'b0} > (ADI_W+1)'(thr))
			&& ((24'(adv) * RWIN_LO_MUL) >= 24'(adi))
			&& ((20'(adv) * RWIN_HI_MUL) <= adi);
	end

	// shared log unit
	assign log_state = (state_q == B_LOGN) || (state_q == B_LOGA) || (state_q == B_LOGR);
	assign log_start = log_state && !log_busy_q;

	always_comb begin
		if (state_q == B_LOGN) begin
			log_in = acc_q;
		end else if (state_q == B_LOGA) begin
			log_in = LOG_IN_W'(adi_q);
		end else begin
			log_in = LOG_IN_W'(r1_of(row));
		end
	end

	prte_log2 u_log2 (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (log_start),
		.n      (log_in),
		.done   (log_done),
		.result (log_res)
	);

	// log difference, divider step, average bias
	always_comb begin
		d      = D_W'(ln_q) - D_W'(la_q) - D_W'(lr_q);
		rem_sh = {rem_q[REM_W-2:0], dnum_q[DIV_W-1]};
		ge     = rem_sh >= REM_W'(dden_q);
		biased = 32'(sum_q) + signed'(32'(fill_q) * 32'(TEMP_BIAS));
	end

	assign out_free = !out_valid_q || out_ready;
	assign q_pop    = (state_q == B_IDLE) && !q_empty;

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			log_busy_q  <= 1'b0;
			wp_q        <= '0;
			fill_q      <= '0;
			est_q       <= TEMP_RESET;
			est_valid_q <= 1'b0;
			upd_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (log_start) begin
				log_busy_q <= 1'b1;
			end else if (log_done) begin
				log_busy_q <= 1'b0;
			end
			unique case (state_q)
				B_IDLE: begin
					upd_q <= 1'b0;
					if (!q_empty) begin
						state_q <= q_job.est ? B_CHK : B_OUT;
					end
				end
				B_CHK:  state_q <= chk_pass ? B_NUM : B_OUT;
				B_NUM: begin
					if (cnt_q == '0) begin
						state_q <= (acc_q > 0) ? B_LOGN : B_OUT;
					end
				end
				B_LOGN: if (log_done) state_q <= B_LOGA;
				B_LOGA: if (log_done) state_q <= B_LOGR;
				B_LOGR: if (log_done) state_q <= B_MULT;
				B_MULT: state_q <= (d > 0) ? B_DSET : B_OUT;
				B_DSET: state_q <= B_DIV;
				B_DIV: begin
					if (cnt_q == CNT_W'(1)) begin
						state_q <= avg_q ? B_AVG : B_TCHK;
					end
				end
				B_TCHK: begin
					state_q <= (dnum_q >= TCK_MIN && dnum_q <= TCK_MAX) ? B_PUSH : B_OUT;
				end
				B_PUSH: begin
					wp_q <= (wp_q == WP_W'(WINDOW - 1)) ? '0 : wp_q + 1'b1;
					if (fill_q != FC_W'(WINDOW)) begin
						fill_q <= fill_q + 1'b1;
					end
					state_q <= B_SUM;
				end
				B_SUM: begin
					if (idx_q >= fill_q) begin
						state_q <= B_DIV;
					end
				end
				B_AVG: begin
					est_q       <= dnum_q[TEMP_W-1:0] - TEMP_BIAS;
					est_valid_q <= 1'b1;
					upd_q       <= 1'b1;
					state_q     <= B_OUT;
				end
				B_OUT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= B_IDLE;
					end
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		case (state_q)
			B_IDLE: begin
				if (!q_empty) begin
					job_q <= q_job;
				end
			end
			B_CHK: begin
				adi_q   <= adi;
				mi_q    <= adi;
				mv_q    <= adv;
				acc_q   <= '0;
				aterm_q <= PICO_PER_OHM;
				bterm_q <= ACC_W'(r0_of(row));
				cnt_q   <= CNT_W'(NUM_STEPS);
			end
			B_NUM: begin
				// NUM = |dV| * 1e12 - r0 * |dI|, one multiplier bit per cycle
				if (cnt_q != '0) begin
					acc_q   <= acc_q + (mv_q[0] ? aterm_q : '0) - (mi_q[0] ? bterm_q : '0);
					aterm_q <= aterm_q <<< 1;
					bterm_q <= bterm_q <<< 1;
					mv_q    <= mv_q >> 1;
					mi_q    <= mi_q >> 1;
					cnt_q   <= cnt_q - 1'b1;
				end
			end
			B_LOGN: if (log_done) ln_q <= log_res;
			B_LOGA: if (log_done) la_q <= log_res;
			B_LOGR: if (log_done) lr_q <= log_res;
			B_MULT: begin
				d_q    <= d[DEN_W-1:0];
				prod_q <= DIV_W'(ea_of(row)) * DIV_W'(TEMP_SCALE);
			end
			B_DSET: begin
				dnum_q <= prod_q + DIV_W'(d_q >> 1);
				dden_q <= d_q;
				rem_q  <= '0;
				cnt_q  <= CNT_W'(DIV_W);
				avg_q  <= 1'b0;
			end
			B_DIV: begin
				// restoring division, one quotient bit per cycle
				rem_q  <= ge ? rem_sh - REM_W'(dden_q) : rem_sh;
				dnum_q <= {dnum_q[DIV_W-2:0], ge};
				cnt_q  <= cnt_q - 1'b1;
			end
			B_TCHK: t_q <= TEMP_W'(dnum_q[15:0] - KELVIN_CENTI);
			B_PUSH: begin
				sum_q <= '0;
				idx_q <= '0;
			end
			B_SUM: begin
				if (idx_q < fill_q) begin
					sum_q <= sum_q + SUM_W'(hist_q[idx_q[WP_W-1:0]]);
					idx_q <= idx_q + 1'b1;
				end else begin
					// rounded mean: (2 * biased + n) / (2 * n)
					dnum_q <= DIV_W'({biased[30:0], 1'b0}) + DIV_W'(fill_q);
					dden_q <= DEN_W'({fill_q, 1'b0});
					rem_q  <= '0;
					cnt_q  <= CNT_W'(DIV_W);
					avg_q  <= 1'b1;
				end
			end
			B_OUT: begin
				if (out_free) begin
					out_temp_q <= est_q;
					out_tv_q   <= est_valid_q;
					out_upd_q  <= upd_q;
					out_pend_q <= job_q.pending;
				end
			end
			default: ;
		endcase
	end

	// history entries, valid only up to the fill count
	always_ff @(posedge clk) begin
		if (state_q == B_PUSH) begin
			hist_q[wp_q] <= signed'(t_q);
		end
	end

	assign out_valid        = out_valid_q;
	assign temp_centi_c     = signed'(out_temp_q);
	assign temp_valid       = out_tv_q;
	assign estimate_updated = out_upd_q;
	assign pulse_pending    = out_pend_q;

	a_upd_implies_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_upd_q) |-> out_tv_q)
		else $error("update reported without a valid estimate");
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FC_W'(WINDOW)) else $error("fill count beyond window");
	a_log_owner: assert property (@(posedge clk) disable iff (!arst_n)
		log_done |-> (state_q == B_LOGN || state_q == B_LOGA || state_q == B_LOGR))
		else $error("log result outside a log state");

endmodule

`default_nettype wire

// File: rtl/core/pulse_resistance_temp_estimator_unit.sv
// Top level of the pulse resistance temperature estimator: configuration
// registers, front end, job queue and back end. Depends on prte_pkg.
//
// Usage: one sample (current_ma, voltage_mv, time_ms) is a request on the
// in channel; every sample yields exactly one result request on the out
// channel (temp_centi_c, temp_valid, estimate_updated, pulse_pending), in
// order. Configuration writes (cfg_index 0..2, cfg_data) are always
// taken; an index past the register list is ignored.
// The front end takes each sample and the queue holds up to four jobs.
// A sample that needs no estimate goes from idle straight to the output
// state in the back end. The settle sample of a pulse that passes the
// checks runs the numerator accumulation, three logarithms on one shared
// log unit, and two passes of one restoring divider around a sum over the
// averaging window; a failed check ends this early.
// Reset clears pulse tracking, anchors, the average (25.00 degC, invalid)
// and restores register defaults. A stalled receiver holds the result in
// the output register; the queue then fills and in_ready drops.
`default_nettype none

module pulse_resistance_temp_estimator_unit #(
	parameter int WINDOW = 8
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic signed [prte_pkg::CUR_W-1:0]     current_ma,
	input  logic [prte_pkg::VOLT_W-1:0]           voltage_mv,
	input  logic [prte_pkg::TIME_W-1:0]           time_ms,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic signed [prte_pkg::TEMP_W-1:0]    temp_centi_c,
	output logic                                  temp_valid,
	output logic                                  estimate_updated,
	output logic                                  pulse_pending,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [prte_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [prte_pkg::CFG_DATA_W-1:0]       cfg_data
);
	import prte_pkg::*;

	logic [SOC_W-1:0]    soc_q;
	logic [THR_W-1:0]    thr_q;
	logic [SETTLE_W-1:0] settle_q;

	logic q_push;
	logic q_full;
	logic q_pop;
	logic q_empty;
	job_t push_job;
	job_t head_job;

	assign cfg_ready = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			soc_q    <= SOC_RESET;
			thr_q    <= THR_RESET;
			settle_q <= SETTLE_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_SOC:    soc_q    <= cfg_data[SOC_W-1:0];
				CFG_THR:    thr_q    <= cfg_data[THR_W-1:0];
				CFG_SETTLE: settle_q <= cfg_data[SETTLE_W-1:0];
				default: ;
			endcase
		end
	end

	prte_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.current_ma (current_ma),
		.voltage_mv (voltage_mv),
		.time_ms    (time_ms),
		.thr        (thr_q),
		.settle_ms  (settle_q),
		.q_full     (q_full),
		.q_push     (q_push),
		.q_job      (push_job)
	);

	prte_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_job (push_job),
		.full     (q_full),
		.pop      (q_pop),
		.head     (head_job),
		.empty    (q_empty)
	);

	prte_back #(
		.WINDOW (WINDOW)
	) u_back (
		.clk              (clk),
		.arst_n           (arst_n),
		.q_empty          (q_empty),
		.q_pop            (q_pop),
		.q_job            (head_job),
		.soc              (soc_q),
		.thr              (thr_q),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.temp_centi_c     (temp_centi_c),
		.temp_valid       (temp_valid),
		.estimate_updated (estimate_updated),
		.pulse_pending    (pulse_pending)
	);

endmodule

`default_nettype wire

// File: tb/prte_checker.sv
// Checker for the pulse resistance temperature estimator: watches the sample,
// result and register channels, predicts each result and compares it.
// Depends on prte_pkg for port widths and register indexes.
`timescale 1ns / 100ps

module prte_checker (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	input  logic                               in_ready,
	input  logic signed [prte_pkg::CUR_W-1:0]  current_ma,
	input  logic [prte_pkg::VOLT_W-1:0]        voltage_mv,
	input  logic [prte_pkg::TIME_W-1:0]        time_ms,
	input  logic                               out_valid,
	input  logic                               out_ready,
	input  logic signed [prte_pkg::TEMP_W-1:0] temp_centi_c,
	input  logic                               temp_valid,
	input  logic                               estimate_updated,
	input  logic                               pulse_pending,
	input  logic                               cfg_valid,
	input  logic                               cfg_ready,
	input  logic [prte_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [prte_pkg::CFG_DATA_W-1:0]    cfg_data,
	output int                                 fails,
	output int                                 outstanding
);
	import prte_pkg::*;

	localparam int HIST_N = 8;
	localparam longint unsigned ARR_SCALE = (64'd1 << 24) * 64'd1000000000 / 64'd597308025;

	typedef struct {
		logic signed [TEMP_W-1:0] temp;
		logic                     tvalid;
		logic                     updated;
		logic                     pending;
	} temp_result_t;

	// Arrhenius coefficients per soc row
	longint arr_r0 [11] = '{-64'sd81636000000, -64'sd81636000000, 64'sd5101000000,
		64'sd9964000000, 64'sd9108000000, 64'sd4168000000, 64'sd1307000000,
		64'sd4737000000, 64'sd10057000000, 64'sd6521000000, 64'sd6521000000};
	longint arr_r1 [11] = '{64'sd34802540000, 64'sd34802540000, 64'sd3867334, 64'sd17609,
		64'sd97125, 64'sd5307442, 64'sd20457790, 64'sd1997041, 64'sd12824,
		64'sd430475, 64'sd430475};
	longint arr_ea [11] = '{27305, 27305, 206345, 329481, 290453, 200746, 171306,
		224720, 342309, 262706, 262706};

	temp_result_t temp_q[$];

	// predictor copy of registers and state
	logic [SOC_W-1:0]    soc_r;
	logic [THR_W-1:0]    thr_r;
	logic [SETTLE_W-1:0] wait_r;
	logic                pulse_on;
	logic [31:0]         start_ms;
	int                  anc_cur;
	int                  anc_volt;
	int                  avg_temp;
	logic                avg_ok;
	int                  hist [HIST_N];
	int                  wpos;
	int                  nfill;

	// log2 in Q24: leading one plus 24 squaring steps
	function automatic longint log2_q24(longint unsigned n);
		int k;
		longint unsigned m;
		longint frac;
		k = 0;
		frac = 0;
		while (k < 63 && (n >> (k + 1)) != 0)
			k++;
		if (k >= 30)
			m = n >> (k - 30);
		else
			m = n << (30 - k);
		for (int i = 23; i >= 0; i--) begin
			m = (m * m) >> 30;
			if (m >= (64'd2 << 30)) begin
				m = m >> 1;
				frac |= longint'(1) << i;
			end
		end
		return (longint'(k) << 24) + frac;
	endfunction

	// temperature from one settled step, 0 if rejected
	function automatic bit step_temp(int di, int dv, output int tc);
		longint adi, adv, num, d, tck;
		int row;
		adi = di < 0 ? -di : di;
		adv = dv < 0 ? -dv : dv;
		tc = 0;
		if (2 * adi <= longint'(thr_r))
			return 0;
		if (200 * adv < adi || 10 * adv > adi)
			return 0;
		row = soc_r / 100;
		if (row > 10)
			row = 10;
		num = adv * 64'sd1000000000000 - arr_r0[row] * adi;
		if (num <= 0)
			return 0;
		d = log2_q24(num) - log2_q24(adi) - log2_q24(arr_r1[row]);
		if (d <= 0)
			return 0;
		tck = (arr_ea[row] * longint'(ARR_SCALE) + d / 2) / d;
		tck = tck - 27315;
		if (tck < -2000 || tck > 10000)
			return 0;
		tc = int'(tck);
		return 1;
	endfunction

	// predict, then compare at each handshake
	always @(posedge clk or negedge arst_n) begin
		int diff, tc;
		longint sum, biased;
		temp_result_t want, got;
		bit upd;
		if (!arst_n) begin
			soc_r = SOC_RESET;
			thr_r = THR_RESET;
			wait_r = SETTLE_RESET;
			pulse_on = 0;
			start_ms = 0;
			anc_cur = 0;
			anc_volt = 0;
			avg_temp = 2500;
			avg_ok = 0;
			wpos = 0;
			nfill = 0;
			fails = 0;
			temp_q.delete();
			outstanding = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_SOC:    soc_r = cfg_data[SOC_W-1:0];
					CFG_THR:    thr_r = cfg_data[THR_W-1:0];
					CFG_SETTLE: wait_r = cfg_data[SETTLE_W-1:0];
					default:    ;
				endcase
			end
			if (in_valid && in_ready) begin
				upd = 0;
				if (!pulse_on) begin
					diff = int'(current_ma) - anc_cur;
					if (diff < 0)
						diff = -diff;
					if (diff > int'(thr_r)) begin
						pulse_on = 1;
						start_ms = time_ms;
					end else begin
						anc_cur = current_ma;
						anc_volt = voltage_mv;
					end
				end else if (32'(time_ms - start_ms) >= 32'(wait_r)) begin
					if (step_temp(int'(current_ma) - anc_cur, int'(voltage_mv) - anc_volt, tc)) begin
						hist[wpos] = tc;
						wpos = (wpos + 1) % HIST_N;
						if (nfill < HIST_N)
							nfill++;
						sum = 0;
						for (int i = 0; i < nfill; i++)
							sum += hist[i];
						biased = sum + 2000 * nfill;
						avg_temp = int'((2 * biased + nfill) / (2 * nfill)) - 2000;
						avg_ok = 1;
						upd = 1;
					end
					pulse_on = 0;
					anc_cur = current_ma;
					anc_volt = voltage_mv;
				end
				want.temp = avg_temp[TEMP_W-1:0];
				want.tvalid = avg_ok;
				want.updated = upd;
				want.pending = pulse_on;
				temp_q.push_back(want);
			end
			if (out_valid && out_ready) begin
				got.temp = temp_centi_c;
				got.tvalid = temp_valid;
				got.updated = estimate_updated;
				got.pending = pulse_pending;
				if (temp_q.size() == 0) begin
					$error("result request with no sample waiting");
					fails++;
				end else begin
					want = temp_q.pop_front();
					if (got.temp !== want.temp) begin
						$error("temp_centi_c expected %0d got %0d", want.temp, got.temp);
						fails++;
					end
					if (got.tvalid !== want.tvalid) begin
						$error("temp_valid expected %0b got %0b", want.tvalid, got.tvalid);
						fails++;
					end
					if (got.updated !== want.updated) begin
						$error("estimate_updated expected %0b got %0b", want.updated, got.updated);
						fails++;
					end
					if (got.pending !== want.pending) begin
						$error("pulse_pending expected %0b got %0b", want.pending, got.pending);
						fails++;
					end
				end
			end
			outstanding = temp_q.size();
		end
	end

endmodule

// File: tb/pulse_resistance_temp_estimator_unit_tb.sv
// Top of the estimator testbench: clock, reset, sample and register stimulus,
// result back-pressure and verdict. Depends on prte_pkg and prte_checker.
`timescale 1ns / 100ps

module pulse_resistance_temp_estimator_unit_tb;
	import prte_pkg::*;

	localparam int CYCLE_LIMIT = 1000000;
	localparam int RAND_ITEMS = 900;

	logic                        clk = 0;
	logic                        arst_n = 0;
	logic                        in_valid = 0;
	logic                        in_ready;
	logic signed [CUR_W-1:0]     current_ma = 0;
	logic [VOLT_W-1:0]           voltage_mv = 0;
	logic [TIME_W-1:0]           time_ms = 0;
	logic                        out_valid;
	logic                        out_ready = 1;
	logic signed [TEMP_W-1:0]    temp_centi_c;
	logic                        temp_valid;
	logic                        estimate_updated;
	logic                        pulse_pending;
	logic                        cfg_valid = 0;
	logic                        cfg_ready;
	logic [CFG_IDX_W-1:0]        cfg_index = CFG_SOC;
	logic [CFG_DATA_W-1:0]       cfg_data = 0;
	int                          fails;
	int                          outstanding;
	int                          cycles = 0;

	// stimulus bookkeeping
	logic [31:0] tick = 0;
	int          last_cur = 0;
	int          thr_now = 10000;
	int          wait_now = 150;
	int          sent = 0;

	pulse_resistance_temp_estimator_unit uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.current_ma(current_ma), .voltage_mv(voltage_mv), .time_ms(time_ms),
		.out_valid(out_valid), .out_ready(out_ready),
		.temp_centi_c(temp_centi_c), .temp_valid(temp_valid),
		.estimate_updated(estimate_updated), .pulse_pending(pulse_pending),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	prte_checker chk (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.current_ma(current_ma), .voltage_mv(voltage_mv), .time_ms(time_ms),
		.out_valid(out_valid), .out_ready(out_ready),
		.temp_centi_c(temp_centi_c), .temp_valid(temp_valid),
		.estimate_updated(estimate_updated), .pulse_pending(pulse_pending),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data),
		.fails(fails), .outstanding(outstanding)
	);

	always #5 clk = ~clk;

	// run limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("pulse_resistance_temp_estimator_unit_tb failed");
			$finish;
		end
	end

	// mostly short gaps, a few long ones
	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 65)
			return 0;
		if (r < 95)
			return $urandom_range(1, 3);
		return $urandom_range(20, 60);
	endfunction

	// result back-pressure: one long hold-off while samples keep coming
	initial begin
		int g;
		@(posedge arst_n);
		repeat (60) @(posedge clk);
		out_ready <= 0;
		repeat (400) @(posedge clk);
		forever begin
			g = gap_len();
			if (g > 0) begin
				out_ready <= 0;
				repeat (g) @(posedge clk);
			end
			out_ready <= 1;
			repeat ($urandom_range(1, 20)) @(posedge clk);
		end
	end

	// one sample request, values clamped to the field ranges
	task automatic send(int cur, int volt, logic [31:0] t);
		int g;
		if (cur > 262143) cur = 262143;
		if (cur < -262144) cur = -262144;
		if (volt > 65535) volt = 65535;
		if (volt < 0) volt = 0;
		in_valid <= 1;
		current_ma <= cur[CUR_W-1:0];
		voltage_mv <= volt[VOLT_W-1:0];
		time_ms <= t;
		do @(posedge clk); while (!in_ready);
		last_cur = cur;
		sent++;
		g = gap_len();
		if (g > 0) begin
			in_valid <= 0;
			repeat (g) @(posedge clk);
		end
	endtask

	// wait until every result has come back
	task automatic drain();
		in_valid <= 0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int val);
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data <= val[CFG_DATA_W-1:0];
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 0;
	endtask

	task automatic set_regs(int soc, int thr, int wt);
		drain();
		write_reg(CFG_SOC, soc);
		write_reg(CFG_THR, thr);
		write_reg(CFG_SETTLE, wt);
		thr_now = thr;
		wait_now = wt;
	endtask

	// anchor, step, optional early samples, settle sample
	task automatic pulse(int di, int dv, int di_settle, int early);
		int v0;
		logic [31:0] t0;
		v0 = 32768 + $urandom_range(0, 2000) - 1000;
		tick += $urandom_range(1, 5);
		send(last_cur, v0, tick);
		tick += $urandom_range(1, 5);
		t0 = tick;
		send(last_cur + di, v0 + dv / 2, tick);
		for (int i = 0; i < early && i + 1 < wait_now; i++) begin
			tick = t0 + i + 1;
			send(last_cur, v0 + $urandom_range(0, 100), tick);
		end
		tick = t0 + wait_now + $urandom_range(0, 3);
		send(last_cur - (early > 0 && early + 1 < wait_now ? 0 : di) + di_settle, v0 + dv, tick);
	endtask

	// random well-formed pulse with resistance around the accepted window
	task automatic rand_pulse();
		int amp, di, dv, di2, rm;
		amp = thr_now + 1 + $urandom_range(0, 40000);
		if (amp > 300000)
			amp = 300000;
		if (last_cur + amp > 262143 || (last_cur - amp >= -262144 && $urandom_range(0, 1)))
			di = -amp;
		else
			di = amp;
		rm = $urandom_range(4000, 102000);
		dv = int'(longint'(amp) * rm / 1000000);
		case ($urandom_range(0, 9))
			0: dv = (amp + 199) / 200;
			1: dv = amp / 10;
			2: dv = dv + 1;
			default: ;
		endcase
		if (di > 0)
			dv = -dv;
		di2 = di;
		if ($urandom_range(0, 9) == 0)
			di2 = di / 3;
		else if ($urandom_range(0, 3) == 0)
			di2 = di + $urandom_range(0, 200) - 100;
		pulse(di, dv, di2, $urandom_range(0, 3) == 0 ? $urandom_range(1, 3) : 0);
	endtask

	initial begin
		int ph;
		int soc_tab [7] = '{500, 0, 1000, 1023, 250, 800, 650};
		int thr_tab [7] = '{10000, 0, 262143, 5000, 20000, 1000, 15000};
		int wt_tab [7] = '{150, 0, 65535, 1, 300, 10, 100};
		repeat (4) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: field extremes, time wrap, window edges, recheck, below r0
		send(0, 0, 0);
		send(262143, 65535, 32'hFFFFFFF0);
		send(262143, 65535, 32'h00000010);
		send(-262144, 0, 32'd200);
		tick = 32'd300;
		send(0, 0, tick);
		pulse(-20000, 400, -20000, 0);
		pulse(30000, -3000, 30000, 0);
		pulse(20000, -100, 20000, 0);
		pulse(20000, -99, 20000, 1);
		pulse(-30000, 600, -4000, 0);
		drain();
		write_reg(CFG_SOC, 850);
		write_reg(2'd3, 12345);
		pulse(-20000, 120, -20000, 0);
		send(0, 0, 32'hFFFFFFFF);

		// random phases over several register settings
		for (ph = 0; ph < 7; ph++) begin
			set_regs(soc_tab[ph], thr_tab[ph], wt_tab[ph]);
			while (sent < 25 + (ph + 1) * RAND_ITEMS / 7) begin
				if ($urandom_range(0, 3) != 0) begin
					rand_pulse();
				end else begin
					if ($urandom_range(0, 4) == 0)
						tick = $urandom;
					else
						tick += $urandom_range(0, 400);
					send(int'($urandom_range(0, 524287)) - 262144,
						$urandom_range(0, 65535), tick);
				end
			end
		end

		drain();
		repeat (300) @(posedge clk);
		if (fails == 0 && outstanding == 0) begin
			$display("pulse_resistance_temp_estimator_unit_tb passed");
		end else begin
			$display("pulse_resistance_temp_estimator_unit_tb failed");
		end
		$finish;
	end

endmodule
